/* design/b2da_pkg.sv */
`default_nettype none

package b2da_pkg;

  // Width of the input field, whatever the parameter says
  localparam int FieldBits = 32;
  localparam int DefValueBits = 32;

  // BCD register: ten digits cover any 32-bit value
  localparam int MaxDigits = 10;
  localparam int BcdW = 4 * MaxDigits;
  localparam int DigitCntW = 4;

  localparam logic [5:0] AsciiZero = 6'h30;

  // Double dabble correction: a digit of five or more gets three added
  function automatic logic [3:0] dabble_fix(input logic [3:0] dig);
    logic [3:0] res;
    res = (dig >= 4'd5) ? (dig + 4'd3) : dig;
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter.
// Input channel: in_valid_i / in_stall_o with value_i. A transfer happens on
// a rising edge with in_valid_i high and in_stall_o low. Only the low
// VALUE_BITS bits of value_i (at most 32) are converted.
// Output channel: out_valid_o / out_stall_i with digit_char_o and
// last_digit_o. Digits leave most significant first, leading zeros
// suppressed; zero gives one '0'. last_digit_o marks the final digit.
// Operation: one double dabble step per input bit (VALUE_BITS of them, capped
// at 32), then one step per BCD position (ten) to skip a leading zero or emit
// a digit. Leading zeros are skipped even while the output is stalled; a
// digit to be emitted waits until the output register is free.
// in_stall_o is high from the transfer until the last digit is loaded into
// the output register, so the next value is taken while that digit waits.
// A stalled output holds its digit unchanged.
// Reset (rst_ni low, asynchronous) returns to idle with no output valid.
`default_nettype none

module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int VALUE_BITS = DefValueBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [FieldBits-1:0] value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [5:0]           digit_char_o,
  output logic                      last_digit_o
);

  localparam int EffBits = (VALUE_BITS < FieldBits) ? VALUE_BITS : FieldBits;
  localparam int CntW = $clog2(EffBits);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [EffBits-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]      bcd_q, bcd_d, bcd_step;
  logic [DigitCntW-1:0] rem_q, rem_d;
  logic                 started_q, started_d;
  logic                 out_valid_q, out_valid_d;
  logic [5:0]           digit_q, digit_d;
  logic                 last_q, last_d;

  logic [3:0] top_dig;
  logic       out_free;
  logic       skip;

  // Shared conversion step
  b2da_dabble_step u_step (
    .bcd_i (bcd_q),
    .bit_i (bin_q[EffBits-1]),
    .bcd_o (bcd_step)
  );

  assign top_dig  = bcd_q[BcdW-1 -: 4];
  assign out_free = !out_valid_q || !out_stall_i;
  assign skip     = !started_q && (top_dig == 4'd0) && (rem_q != DigitCntW'(1));

  // Sequencer: load, convert bit by bit, then walk the digits
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    rem_d       = rem_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    digit_d     = digit_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          bin_d   = value_i[EffBits-1:0];
          bcd_d   = '0;
          cnt_d   = CntW'(EffBits - 1);
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = bcd_step;
        bin_d = {bin_q[EffBits-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          rem_d     = DigitCntW'(MaxDigits);
          started_d = 1'b0;
          state_d   = StEmit;
        end
      end
      StEmit: begin
        if (skip) begin
          bcd_d = {bcd_q[BcdW-5:0], 4'd0};
          rem_d = rem_q - DigitCntW'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          digit_d     = AsciiZero | {2'b00, top_dig};
          last_d      = (rem_q == DigitCntW'(1));
          bcd_d       = {bcd_q[BcdW-5:0], 4'd0};
          rem_d       = rem_q - DigitCntW'(1);
          started_d   = 1'b1;
          if (rem_q == DigitCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    rem_q     <= rem_d;
    started_q <= started_d;
    digit_q   <= digit_d;
    last_q    <= last_d;
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = digit_q;
  assign last_digit_o = last_q;

endmodule

`default_nettype wire

/* design/b2da_dabble_step.sv */
`default_nettype none

// One double dabble step: correct every digit, then shift in the next bit
module b2da_dabble_step
  import b2da_pkg::*;
(
  input  wire logic [BcdW-1:0] bcd_i,
  input  wire logic            bit_i,
  output logic      [BcdW-1:0] bcd_o
);

  logic [BcdW-1:0] fixed;

  // Per-digit correction, digits are independent
  always_comb begin
    for (int i = 0; i < MaxDigits; i++) begin
      fixed[4*i +: 4] = dabble_fix(bcd_i[4*i +: 4]);
    end
  end

  // Shift left by one, new binary bit enters at the bottom
  assign bcd_o = {fixed[BcdW-2:0], bit_i};

endmodule

`default_nettype wire
